### rtl/assert_macros.svh
// Assertion helpers used by the checker file of this block.
// Each macro takes a label, the clock, the reset and the two sides of an implication.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cons must hold in the same cycle as ante
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// cons must hold in the cycle after ante
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/rtc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_pkg
// Shared constants, register codes and width helpers of the ray / triangle
// closest-hit block.
// ----------------------------------------------------------------------------
package rtc_pkg;

   localparam int COORD_BITS_DEF   = 24;
   localparam int FACE_ID_BITS_DEF = 16;

   localparam int DIST_BITS  = 32;
   localparam int FRAC_BITS  = 16;
   localparam int BARY_BITS  = 17;
   localparam int NUM_AXES   = 3;
   localparam int NUM_VEC    = 3;

   // vector slots inside a queue entry
   localparam int VEC_E1 = 0;
   localparam int VEC_E2 = 1;
   localparam int VEC_X  = 2;

   localparam int QUEUE_DEPTH   = 2;
   localparam int CSR_ADDR_BITS = 3;
   localparam int DIR_Z_RESET   = 4096;

   localparam logic [DIST_BITS-1:0] DIST_INF = '1;
   localparam logic [BARY_BITS-1:0] BARY_ONE = BARY_BITS'(1 << FRAC_BITS);

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      REG_ORIGIN_X = 3'd0,
      REG_ORIGIN_Y = 3'd1,
      REG_ORIGIN_Z = 3'd2,
      REG_DIR_X    = 3'd3,
      REG_DIR_Y    = 3'd4,
      REG_DIR_Z    = 3'd5
   } reg_idx_type;

   function automatic int req_bits(int cb, int fb);
      return ((3 * NUM_AXES * cb + fb + 7) / 8) * 8;
   endfunction

   function automatic int rsp_bits(int fb);
      return ((DIST_BITS + fb + 2 * BARY_BITS + 7) / 8) * 8;
   endfunction

   // e1, e2 and origin offset at cb+1 bits each, face index, last flag
   function automatic int entry_bits(int cb, int fb);
      return NUM_VEC * NUM_AXES * (cb + 1) + fb + 1;
   endfunction

endpackage

### rtl/rtc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_front
// Accepts triangle items and forms the edge vectors A-B, A-C and the origin
// offset A-O, registered for the queue.
// ----------------------------------------------------------------------------
module rtc_front import rtc_pkg::*; #(
   parameter int COORD_BITS   = COORD_BITS_DEF,
   parameter int FACE_ID_BITS = FACE_ID_BITS_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_tvalid,
   output logic                                          req_tready,
   input  logic [req_bits(COORD_BITS, FACE_ID_BITS)-1:0] req_tdata,
   input  logic                                          req_tlast,
   input  logic signed [COORD_BITS-1:0]                  org [NUM_AXES],
   output logic                                          ent_valid,
   input  logic                                          ent_ready,
   output logic [entry_bits(COORD_BITS, FACE_ID_BITS)-1:0] ent_data
);

   localparam int DIFF  = COORD_BITS + 1;
   localparam int ENT_W = entry_bits(COORD_BITS, FACE_ID_BITS);
   localparam int FACE_LSB = NUM_VEC * NUM_AXES * DIFF;

   logic signed [COORD_BITS-1:0] va [NUM_AXES];
   logic signed [COORD_BITS-1:0] vb [NUM_AXES];
   logic signed [COORD_BITS-1:0] vc [NUM_AXES];
   logic signed [DIFF-1:0]       e1 [NUM_AXES];
   logic signed [DIFF-1:0]       e2 [NUM_AXES];
   logic signed [DIFF-1:0]       xo [NUM_AXES];
   logic [ENT_W-1:0]             ent_in;
   logic [ENT_W-1:0]             ent_ff;
   logic                         vld_ff;

   always_comb begin
      ent_in = '0;
      for (int k = 0; k < NUM_AXES; k++) begin
         va[k] = $signed(req_tdata[k * COORD_BITS +: COORD_BITS]);
         vb[k] = $signed(req_tdata[(NUM_AXES + k) * COORD_BITS +: COORD_BITS]);
         vc[k] = $signed(req_tdata[(2 * NUM_AXES + k) * COORD_BITS +: COORD_BITS]);
         e1[k] = $signed({va[k][COORD_BITS-1], va[k]}) - $signed({vb[k][COORD_BITS-1], vb[k]});
         e2[k] = $signed({va[k][COORD_BITS-1], va[k]}) - $signed({vc[k][COORD_BITS-1], vc[k]});
         xo[k] = $signed({va[k][COORD_BITS-1], va[k]})
               - $signed({org[k][COORD_BITS-1], org[k]});
         ent_in[(VEC_E1 * NUM_AXES + k) * DIFF +: DIFF] = e1[k];
         ent_in[(VEC_E2 * NUM_AXES + k) * DIFF +: DIFF] = e2[k];
         ent_in[(VEC_X * NUM_AXES + k) * DIFF +: DIFF]  = xo[k];
      end
      ent_in[FACE_LSB +: FACE_ID_BITS] =
         req_tdata[3 * NUM_AXES * COORD_BITS +: FACE_ID_BITS];
      ent_in[ENT_W-1] = req_tlast;
   end

   assign req_tready = !vld_ff || ent_ready;
   assign ent_valid  = vld_ff;
   assign ent_data   = ent_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         vld_ff <= 1'b1;
         ent_ff <= ent_in;
      end else if (ent_ready) begin
         vld_ff <= 1'b0;
      end
   end

endmodule

### rtl/rtc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_queue
// Short register queue between the front end and the solver.
// ----------------------------------------------------------------------------
module rtc_queue import rtc_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   // DEPTH is a power of two, pointers wrap naturally
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    rd_ptr_ff;
   logic [CW-1:0]    cnt_ff;
   logic             push;
   logic             pop;

   assign in_ready  = cnt_ff != CW'(DEPTH);
   assign out_valid = cnt_ff != '0;
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            mem_ff[wr_ptr_ff] <= in_data;
            wr_ptr_ff         <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

endmodule

### rtl/rtc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_div
// Restoring divider: floor(num * 2^16 / den), saturated to 32 bits, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module rtc_div import rtc_pkg::*; #(
   parameter int DW = 80
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DW-1:0]        num,
   input  logic [DW-1:0]        den,
   output logic                 done,
   output logic [DIST_BITS-1:0] quo
);

   localparam int CNT_W = $clog2(DIST_BITS + 1);

   logic [DW-1:0]        r_ff;
   logic [DIST_BITS-1:0] sh_ff;
   logic [DIST_BITS-1:0] q_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic                 run_ff;
   logic                 done_ff;
   logic [DW:0]          r2;
   logic                 ge;
   logic                 sat;

   // quotient would not fit in 32 bits
   assign sat = {{FRAC_BITS{1'b0}}, num} >= {den, {FRAC_BITS{1'b0}}};
   assign r2  = {r_ff, sh_ff[DIST_BITS-1]};
   assign ge  = r2 >= {1'b0, den};

   assign done = done_ff;
   assign quo  = q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            if (sat) begin
               q_ff    <= DIST_INF;
               done_ff <= 1'b1;
            end else begin
               r_ff   <= num >> FRAC_BITS;
               sh_ff  <= DIST_BITS'(num[FRAC_BITS-1:0]) << (DIST_BITS - FRAC_BITS);
               q_ff   <= '0;
               cnt_ff <= CNT_W'(DIST_BITS);
               run_ff <= 1'b1;
            end
         end else if (run_ff) begin
            r_ff   <= ge ? DW'(r2 - {1'b0, den}) : DW'(r2);
            q_ff   <= {q_ff[DIST_BITS-2:0], ge};
            sh_ff  <= sh_ff << 1;
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

### rtl/rtc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_back
// Solver: Cramer determinants on one shared multiplier, hit test, divisions
// for t, beta and gamma, nearest-hit tracking and the result register.
// ----------------------------------------------------------------------------
module rtc_back import rtc_pkg::*; #(
   parameter int COORD_BITS   = COORD_BITS_DEF,
   parameter int FACE_ID_BITS = FACE_ID_BITS_DEF
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            ent_valid,
   output logic                                            ent_ready,
   input  logic [entry_bits(COORD_BITS, FACE_ID_BITS)-1:0] ent_data,
   input  logic signed [COORD_BITS-1:0]                    dir [NUM_AXES],
   output logic                                            out_valid,
   input  logic                                            out_ready,
   output logic                                            out_hit,
   output logic [DIST_BITS-1:0]                            out_dist,
   output logic [FACE_ID_BITS-1:0]                         out_face,
   output logic [BARY_BITS-1:0]                            out_beta,
   output logic [BARY_BITS-1:0]                            out_gamma
);

   localparam int DIFF     = COORD_BITS + 1;
   localparam int MW       = 2 * DIFF + 1;   // 2x2 minor
   localparam int BW       = DIFF + 1;       // second multiplier operand
   localparam int PW       = DIFF + BW;      // product
   localparam int DW       = 3 * DIFF + 2;   // 3x3 determinant
   localparam int ENT_W    = entry_bits(COORD_BITS, FACE_ID_BITS);
   localparam int FACE_LSB = NUM_VEC * NUM_AXES * DIFF;

   typedef enum logic [3:0] {
      S_IDLE, S_MUL, S_ACC, S_NORM, S_TEST, S_DIV_T, S_WAIT_T,
      S_DIV_B, S_WAIT_B, S_DIV_G, S_WAIT_G, S_FINISH
   } state_type;

   // u = e2 x d, v = x x d, w = e1 x e2; da = e1.u, db = x.u, dg = e1.v, dt = x.w
   typedef enum logic [2:0] {
      GRP_U, GRP_V, GRP_W, GRP_DA, GRP_DB, GRP_DG, GRP_DT
   } grp_type;

   state_type state_ff;
   grp_type   grp_ff;
   logic [1:0] comp_ff;
   logic       sub_ff;

   logic signed [DIFF-1:0] e1_ff [NUM_AXES];
   logic signed [DIFF-1:0] e2_ff [NUM_AXES];
   logic signed [DIFF-1:0] x_ff  [NUM_AXES];
   logic signed [DIFF-1:0] d_ff  [NUM_AXES];
   logic signed [MW-1:0]   u_ff  [NUM_AXES];
   logic signed [MW-1:0]   v_ff  [NUM_AXES];
   logic signed [MW-1:0]   w_ff  [NUM_AXES];
   logic signed [DW-1:0]   da_ff, db_ff, dg_ff, dt_ff;
   logic signed [DW-1:0]   acc_ff;
   logic signed [PW-1:0]   prod_ff;
   logic [FACE_ID_BITS-1:0] face_ff;
   logic                    last_ff;
   logic [DIST_BITS-1:0]    tq_ff;
   logic [BARY_BITS-1:0]    beta_ff;

   logic                    found_ff;
   logic [DIST_BITS-1:0]    best_dist_ff;
   logic [FACE_ID_BITS-1:0] best_face_ff;
   logic [BARY_BITS-1:0]    best_beta_ff;
   logic [BARY_BITS-1:0]    best_gamma_ff;

   logic                    out_valid_ff;
   logic                    out_hit_ff;
   logic [DIST_BITS-1:0]    out_dist_ff;
   logic [FACE_ID_BITS-1:0] out_face_ff;
   logic [BARY_BITS-1:0]    out_beta_ff;
   logic [BARY_BITS-1:0]    out_gamma_ff;

   logic signed [DIFF-1:0] sel_q [NUM_AXES];
   logic signed [DIFF-1:0] sel_s [NUM_AXES];
   logic signed [DIFF-1:0] sel_p [NUM_AXES];
   logic signed [MW-1:0]   sel_m [NUM_AXES];
   logic                   is_cross;
   logic signed [DIFF-1:0] mul_a;
   logic signed [BW-1:0]   mul_b;
   logic signed [DW-1:0]   prod_x;
   logic signed [DW-1:0]   term;
   logic signed [DW-1:0]   dot_sum;
   logic signed [MW-1:0]   mnew;
   logic signed [DW+1:0]   daw, dbw, dgw, dtw, rem1, rem2;
   logic                   hit_cond;
   logic                   div_start;
   logic [DW-1:0]          div_num;
   logic                   div_done;
   logic [DIST_BITS-1:0]   div_quo;
   logic                   comp_end;
   logic                   out_free;
   logic                   rsp_load;

   // operand sets of the current group
   always_comb begin
      sel_q = e2_ff;
      sel_s = d_ff;
      sel_p = e1_ff;
      sel_m = u_ff;
      unique case (grp_ff)
         GRP_U: begin
            sel_q = e2_ff;
            sel_s = d_ff;
         end
         GRP_V: begin
            sel_q = x_ff;
            sel_s = d_ff;
         end
         GRP_W: begin
            sel_q = e1_ff;
            sel_s = e2_ff;
         end
         GRP_DA: begin
            sel_p = e1_ff;
            sel_m = u_ff;
         end
         GRP_DB: begin
            sel_p = x_ff;
            sel_m = u_ff;
         end
         GRP_DG: begin
            sel_p = e1_ff;
            sel_m = v_ff;
         end
         GRP_DT: begin
            sel_p = x_ff;
            sel_m = w_ff;
         end
         default: begin
            sel_q = e2_ff;
         end
      endcase
   end

   // vectors rotate after every component, so each step reads fixed slots
   always_comb begin
      is_cross = grp_ff < GRP_DA;
      if (is_cross) begin
         mul_a = sub_ff ? sel_q[2] : sel_q[1];
         mul_b = sub_ff ? $signed({sel_s[1][DIFF-1], sel_s[1]})
                        : $signed({sel_s[2][DIFF-1], sel_s[2]});
      end else begin
         mul_a = sel_p[0];
         mul_b = sub_ff ? $signed({1'b0, sel_m[0][DIFF-1:0]})
                        : $signed(sel_m[0][MW-1:DIFF]);
      end
      prod_x   = $signed({{(DW-PW){prod_ff[PW-1]}}, prod_ff});
      term     = sub_ff ? prod_x : (prod_x <<< DIFF);
      dot_sum  = ((comp_ff == 2'd0 && !sub_ff) ? '0 : acc_ff) + term;
      mnew     = MW'(acc_ff - prod_x);
      comp_end = sub_ff;
   end

   always_comb begin
      daw      = da_ff;
      dbw      = db_ff;
      dgw      = dg_ff;
      dtw      = dt_ff;
      rem1     = daw - dbw;
      rem2     = rem1 - dgw;
      hit_cond = (daw != '0) && !dbw[DW+1] && !rem1[DW+1] && !dgw[DW+1]
              && !rem2[DW+1] && !dtw[DW+1] && (dtw != '0);
   end

   always_comb begin
      div_start = (state_ff == S_DIV_T) || (state_ff == S_DIV_B) || (state_ff == S_DIV_G);
      case (state_ff)
         S_DIV_B: div_num = $unsigned(db_ff);
         S_DIV_G: div_num = $unsigned(dg_ff);
         default: div_num = $unsigned(dt_ff);
      endcase
   end

   rtc_div #(.DW(DW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   ($unsigned(da_ff)),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign ent_ready = state_ff == S_IDLE;
   assign out_free  = !out_valid_ff || out_ready;
   assign rsp_load  = (state_ff == S_FINISH) && last_ff && out_free;
   assign out_valid = out_valid_ff;
   assign out_hit   = out_hit_ff;
   assign out_dist  = out_dist_ff;
   assign out_face  = out_face_ff;
   assign out_beta  = out_beta_ff;
   assign out_gamma = out_gamma_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         grp_ff        <= GRP_U;
         comp_ff       <= 2'd0;
         sub_ff        <= 1'b0;
         found_ff      <= 1'b0;
         best_dist_ff  <= DIST_INF;
         best_face_ff  <= '0;
         best_beta_ff  <= '0;
         best_gamma_ff <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (rsp_load) begin
            out_valid_ff <= 1'b1;
         end else if (out_valid_ff && out_ready) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (ent_valid) begin
                  for (int k = 0; k < NUM_AXES; k++) begin
                     e1_ff[k] <= $signed(ent_data[(VEC_E1 * NUM_AXES + k) * DIFF +: DIFF]);
                     e2_ff[k] <= $signed(ent_data[(VEC_E2 * NUM_AXES + k) * DIFF +: DIFF]);
                     x_ff[k]  <= $signed(ent_data[(VEC_X * NUM_AXES + k) * DIFF +: DIFF]);
                     d_ff[k]  <= $signed({dir[k][COORD_BITS-1], dir[k]});
                  end
                  face_ff  <= ent_data[FACE_LSB +: FACE_ID_BITS];
                  last_ff  <= ent_data[ENT_W-1];
                  grp_ff   <= GRP_U;
                  comp_ff  <= 2'd0;
                  sub_ff   <= 1'b0;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               prod_ff  <= mul_a * mul_b;
               state_ff <= S_ACC;
            end
            S_ACC: begin
               if (is_cross) begin
                  if (!sub_ff) begin
                     acc_ff <= prod_x;
                  end
               end else begin
                  acc_ff <= dot_sum;
                  if (comp_ff == 2'd2 && sub_ff) begin
                     case (grp_ff)
                        GRP_DA:  da_ff <= dot_sum;
                        GRP_DB:  db_ff <= dot_sum;
                        GRP_DG:  dg_ff <= dot_sum;
                        default: dt_ff <= dot_sum;
                     endcase
                  end
               end
               if (comp_end) begin
                  e1_ff <= '{e1_ff[1], e1_ff[2], e1_ff[0]};
                  e2_ff <= '{e2_ff[1], e2_ff[2], e2_ff[0]};
                  x_ff  <= '{x_ff[1], x_ff[2], x_ff[0]};
                  d_ff  <= '{d_ff[1], d_ff[2], d_ff[0]};
                  // the minor being built shifts in its new component
                  if (grp_ff == GRP_U) u_ff <= '{u_ff[1], u_ff[2], mnew};
                  else                 u_ff <= '{u_ff[1], u_ff[2], u_ff[0]};
                  if (grp_ff == GRP_V) v_ff <= '{v_ff[1], v_ff[2], mnew};
                  else                 v_ff <= '{v_ff[1], v_ff[2], v_ff[0]};
                  if (grp_ff == GRP_W) w_ff <= '{w_ff[1], w_ff[2], mnew};
                  else                 w_ff <= '{w_ff[1], w_ff[2], w_ff[0]};
               end
               sub_ff <= !sub_ff;
               if (sub_ff) begin
                  if (comp_ff == 2'd2) begin
                     comp_ff <= 2'd0;
                     grp_ff  <= grp_type'(grp_ff + 3'd1);
                  end else begin
                     comp_ff <= comp_ff + 2'd1;
                  end
               end
               if (grp_ff == GRP_DT && comp_ff == 2'd2 && sub_ff) begin
                  state_ff <= S_NORM;
               end else begin
                  state_ff <= S_MUL;
               end
            end
            S_NORM: begin
               if (da_ff[DW-1]) begin
                  da_ff <= -da_ff;
                  db_ff <= -db_ff;
                  dg_ff <= -dg_ff;
                  dt_ff <= -dt_ff;
               end
               state_ff <= S_TEST;
            end
            S_TEST: begin
               state_ff <= hit_cond ? S_DIV_T : S_FINISH;
            end
            S_DIV_T: begin
               state_ff <= S_WAIT_T;
            end
            S_WAIT_T: begin
               if (div_done) begin
                  tq_ff <= div_quo;
                  if (!found_ff || div_quo < best_dist_ff) begin
                     state_ff <= S_DIV_B;
                  end else begin
                     state_ff <= S_FINISH;
                  end
               end
            end
            S_DIV_B: begin
               state_ff <= S_WAIT_B;
            end
            S_WAIT_B: begin
               if (div_done) begin
                  beta_ff  <= div_quo[BARY_BITS-1:0];
                  state_ff <= S_DIV_G;
               end
            end
            S_DIV_G: begin
               state_ff <= S_WAIT_G;
            end
            S_WAIT_G: begin
               if (div_done) begin
                  found_ff      <= 1'b1;
                  best_dist_ff  <= tq_ff;
                  best_face_ff  <= face_ff;
                  best_beta_ff  <= beta_ff;
                  best_gamma_ff <= div_quo[BARY_BITS-1:0];
                  state_ff      <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (!last_ff) begin
                  state_ff <= S_IDLE;
               end else if (out_free) begin
                  // without a hit the kept values still hold their cleared state
                  out_hit_ff    <= found_ff;
                  out_dist_ff   <= best_dist_ff;
                  out_face_ff   <= best_face_ff;
                  out_beta_ff   <= best_beta_ff;
                  out_gamma_ff  <= best_gamma_ff;
                  found_ff      <= 1'b0;
                  best_dist_ff  <= DIST_INF;
                  best_face_ff  <= '0;
                  best_beta_ff  <= '0;
                  best_gamma_ff <= '0;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

### rtl/ray_triangle_closest_hit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_triangle_closest_hit_top
// Closest-hit ray / triangle intersection over a streamed mesh.
// ----------------------------------------------------------------------------
// Usage:
//   The ray is set through the csr_ port (registers 0..2 origin, 3..5
//   direction, signed Q12.12) while the block is idle. Triangles then stream
//   in on req_: tdata carries a_x..c_z and face_id, tlast marks the last
//   triangle of the ray. On that item one result leaves on rsp_: tuser is the
//   hit flag, tdata holds distance (Q16.16), face, beta and gamma (Q1.16).
//   A triangle that misses ends in the solver at the hit test, one that hits
//   no nearer than the kept hit adds the division for t, and one that
//   replaces it adds the divisions for beta and gamma as well. The four
//   determinants run as 42 multiplies through one shared multiplier, and
//   each division runs on the bit-serial divider, which skips its bit loop
//   when the distance saturates. The front end and a two-entry queue absorb
//   items while the solver is busy. Reset clears the kept hit, the queue
//   and the result valid flag and loads the default ray (origin 0,
//   direction +z). A stalled receiver holds the result; the solver waits
//   on a further last item until the result register is free.
// ----------------------------------------------------------------------------
module ray_triangle_closest_hit_top import rtc_pkg::*; #(
   parameter int COORD_BITS   = COORD_BITS_DEF,
   parameter int FACE_ID_BITS = FACE_ID_BITS_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_tvalid,
   output logic                                          req_tready,
   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, face_id
   input  logic [req_bits(COORD_BITS, FACE_ID_BITS)-1:0] req_tdata,
   input  logic                                          req_tlast,
   output logic                                          rsp_tvalid,
   input  logic                                          rsp_tready,
   // hit_distance, hit_face, bary_beta, bary_gamma
   output logic [rsp_bits(FACE_ID_BITS)-1:0]             rsp_tdata,
   // hit
   output logic [0:0]                                    rsp_tuser,
   input  logic                                          csr_we,
   input  logic [CSR_ADDR_BITS-1:0]                      csr_addr,
   input  logic [COORD_BITS-1:0]                         csr_wdata
);

   localparam int ENT_W = entry_bits(COORD_BITS, FACE_ID_BITS);
   localparam int RSP_W = rsp_bits(FACE_ID_BITS);

   logic signed [COORD_BITS-1:0] org_ff [NUM_AXES];
   logic signed [COORD_BITS-1:0] dir_ff [NUM_AXES];

   logic                    f_valid, f_ready;
   logic [ENT_W-1:0]        f_data;
   logic                    q_valid, q_ready;
   logic [ENT_W-1:0]        q_data;
   logic                    o_hit;
   logic [DIST_BITS-1:0]    o_dist;
   logic [FACE_ID_BITS-1:0] o_face;
   logic [BARY_BITS-1:0]    o_beta;
   logic [BARY_BITS-1:0]    o_gamma;

   always_ff @(posedge clock) begin
      if (reset) begin
         org_ff <= '{'0, '0, '0};
         dir_ff <= '{'0, '0, COORD_BITS'(DIR_Z_RESET)};
      end else if (csr_we) begin
         unique case (reg_idx_type'(csr_addr))
            REG_ORIGIN_X: org_ff[0] <= csr_wdata;
            REG_ORIGIN_Y: org_ff[1] <= csr_wdata;
            REG_ORIGIN_Z: org_ff[2] <= csr_wdata;
            REG_DIR_X:    dir_ff[0] <= csr_wdata;
            REG_DIR_Y:    dir_ff[1] <= csr_wdata;
            REG_DIR_Z:    dir_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   rtc_front #(
      .COORD_BITS   (COORD_BITS),
      .FACE_ID_BITS (FACE_ID_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .org        (org_ff),
      .ent_valid  (f_valid),
      .ent_ready  (f_ready),
      .ent_data   (f_data)
   );

   rtc_queue #(
      .WIDTH (ENT_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (f_data),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_data)
   );

   rtc_back #(
      .COORD_BITS   (COORD_BITS),
      .FACE_ID_BITS (FACE_ID_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .ent_valid (q_valid),
      .ent_ready (q_ready),
      .ent_data  (q_data),
      .dir       (dir_ff),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_hit   (o_hit),
      .out_dist  (o_dist),
      .out_face  (o_face),
      .out_beta  (o_beta),
      .out_gamma (o_gamma)
   );

   assign rsp_tdata = RSP_W'({o_gamma, o_beta, o_face, o_dist});
   assign rsp_tuser = o_hit;

endmodule

### rtl/rtc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_checker
// Port-level checks on the result channel of the closest-hit block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rtc_checker import rtc_pkg::*; #(
   parameter int FACE_ID_BITS = FACE_ID_BITS_DEF
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [rsp_bits(FACE_ID_BITS)-1:0] rsp_tdata,
   input logic [0:0]                        rsp_tuser
);

   localparam int FACE_LSB  = DIST_BITS;
   localparam int BETA_LSB  = FACE_LSB + FACE_ID_BITS;
   localparam int GAMMA_LSB = BETA_LSB + BARY_BITS;

   logic [DIST_BITS-1:0]    rsp_dist;
   logic [FACE_ID_BITS-1:0] face;
   logic [BARY_BITS-1:0]    beta;
   logic [BARY_BITS-1:0]    gamma;
   logic [BARY_BITS:0]      bary_sum;

   assign rsp_dist = rsp_tdata[DIST_BITS-1:0];
   assign face     = rsp_tdata[FACE_LSB +: FACE_ID_BITS];
   assign beta     = rsp_tdata[BETA_LSB +: BARY_BITS];
   assign gamma    = rsp_tdata[GAMMA_LSB +: BARY_BITS];
   assign bary_sum = {1'b0, beta} + {1'b0, gamma};

   // a stalled result holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // a miss reports the cleared values
   `ASSERT_IMPL(a_miss_clear, clock, reset, rsp_tvalid && !rsp_tuser[0],
                rsp_dist == DIST_INF && face == '0 && beta == '0 && gamma == '0)

   // a hit lies inside the triangle
   `ASSERT_IMPL(a_hit_bary, clock, reset, rsp_tvalid && rsp_tuser[0],
                bary_sum <= {1'b0, BARY_ONE})

endmodule

bind ray_triangle_closest_hit_top rtc_checker #(
   .FACE_ID_BITS (FACE_ID_BITS)
) u_rtc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
